FILE: rtl/core/sidl_pkg.sv
// Shared types and constants of the sorted id list insert block.
`default_nettype none

package sidl_pkg;

    localparam int ID_W   = 64;
    localparam int PL_W   = 32;
    localparam int IDX_W  = 6;
    localparam int ST_W   = 3;
    localparam int POS_W  = 7;
    localparam int KIND_W = 2;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 112;

    localparam logic [ID_W-1:0] DEFAULT_ID = {ID_W{1'b1}};

    // Command kinds as classified by the front end
    localparam logic [KIND_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] CMD_IGNORE = 2'd1;
    localparam logic [KIND_W-1:0] CMD_READ   = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_IGNORED  = 3'd0;
    localparam logic [ST_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [ST_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [ST_W-1:0] ST_APPENDED = 3'd3;
    localparam logic [ST_W-1:0] ST_DROPPED  = 3'd4;
    localparam logic [ST_W-1:0] ST_READ_OK  = 3'd5;
    localparam logic [ST_W-1:0] ST_READ_OOR = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic signed [ID_W-1:0] id;
        logic [PL_W-1:0]        payload;
        logic [IDX_W-1:0]       index;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/sidl_front.sv
// Front end: unpack input items and classify them into commands.
`default_nettype none

module sidl_front (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sidl_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           q_full,
    output logic                                q_push,
    output sidl_pkg::cmd_t                      q_cmd
);

    logic signed [sidl_pkg::ID_W-1:0] in_id;

    assign in_id    = s_tdata[sidl_pkg::ID_W-1:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_cmd.id      = in_id;
        q_cmd.payload = s_tdata[sidl_pkg::ID_W +: sidl_pkg::PL_W];
        q_cmd.index   = s_tdata[sidl_pkg::ID_W + sidl_pkg::PL_W +: sidl_pkg::IDX_W];
        // Read wins over insert; default id inserts are ignored as no-ops
        if (s_tuser) begin
            q_cmd.kind = sidl_pkg::CMD_READ;
        end else if (in_id == sidl_pkg::DEFAULT_ID) begin
            q_cmd.kind = sidl_pkg::CMD_IGNORE;
        end else begin
            q_cmd.kind = sidl_pkg::CMD_INSERT;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sidl_queue.sv
// Two-entry command queue between front end and back end.
`default_nettype none

module sidl_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire sidl_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output sidl_pkg::cmd_t      head_cmd
);

    sidl_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sidl_back.sv
// Back end: row of sorted cells, compare then update, and the result register.
`default_nettype none

module sidl_back #(
    parameter int DEPTH = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    input  wire sidl_pkg::cmd_t                 q_cmd,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [sidl_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [sidl_pkg::ST_W-1:0]           m_tuser
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int RW = sidl_pkg::POS_W + sidl_pkg::POS_W + sidl_pkg::ID_W + sidl_pkg::PL_W;

    localparam logic S_LOOK = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                             state_reg;
    logic [FW-1:0]                    fill_reg;

    logic signed [sidl_pkg::ID_W-1:0] id_cell_reg [DEPTH];
    logic [sidl_pkg::PL_W-1:0]        pl_cell_reg [DEPTH];
    logic signed [sidl_pkg::ID_W-1:0] id_prev     [DEPTH];
    logic [sidl_pkg::PL_W-1:0]        pl_prev     [DEPTH];

    sidl_pkg::cmd_t                   cmd_reg;
    logic [DEPTH-1:0]                 gt_reg;
    logic [DEPTH-1:0]                 eq_reg;
    logic                             rd_ok_reg;
    logic signed [sidl_pkg::ID_W-1:0] rd_id_reg;
    logic [sidl_pkg::PL_W-1:0]        rd_pl_reg;

    logic                             m_valid_reg;
    logic [sidl_pkg::M_TDATA_W-1:0]   m_data_reg;
    logic [sidl_pkg::ST_W-1:0]        m_user_reg;

    logic [DEPTH-1:0]                 valid_c;
    logic [DEPTH-1:0]                 gt_c;
    logic [DEPTH-1:0]                 eq_c;
    logic [DEPTH-1:0]                 rd_sel_c;
    logic signed [sidl_pkg::ID_W-1:0] rd_id_c;
    logic [sidl_pkg::PL_W-1:0]        rd_pl_c;

    logic [DEPTH-1:0]                 gt_prev;
    logic [DEPTH-1:0]                 valid_prev;
    logic [DEPTH-1:0]                 bound_c;
    logic [DEPTH-1:0]                 shift_c;
    logic [FW-1:0]                    pos_c;
    logic                             eq_any;
    logic                             full;
    logic                             out_free;
    logic                             exec_fire;
    logic                             do_ins;
    logic                             do_rep;
    logic [sidl_pkg::ST_W-1:0]        status_c;
    logic [sidl_pkg::POS_W-1:0]       pos_out_c;
    logic [FW-1:0]                    fill_after;
    logic signed [sidl_pkg::ID_W-1:0] out_id_c;
    logic [sidl_pkg::PL_W-1:0]        out_pl_c;
    logic [RW-1:0]                    result_c;

    assign q_pop     = (state_reg == S_LOOK) && q_valid;
    assign out_free  = !m_valid_reg || m_tready;
    assign exec_fire = (state_reg == S_EXEC) && out_free;
    assign full      = (fill_reg == FW'(DEPTH));

    // Per-cell compare against the queue head, and the indexed read select
    always_comb begin
        rd_id_c = '0;
        rd_pl_c = '0;
        for (int i = 0; i < DEPTH; i++) begin
            valid_c[i]  = (FW'(i) < fill_reg);
            gt_c[i]     = valid_c[i] && (id_cell_reg[i] > q_cmd.id);
            eq_c[i]     = valid_c[i] && (id_cell_reg[i] == q_cmd.id);
            rd_sel_c[i] = valid_c[i] && (32'(q_cmd.index) == i);
            rd_id_c     = rd_id_c | (rd_sel_c[i] ? id_cell_reg[i] : '0);
            rd_pl_c     = rd_pl_c | (rd_sel_c[i] ? pl_cell_reg[i] : '0);
        end
    end

    // Neighbor views of the row for the shift
    always_comb begin
        id_prev[0] = '0;
        pl_prev[0] = '0;
        for (int i = 1; i < DEPTH; i++) begin
            id_prev[i] = id_cell_reg[i-1];
            pl_prev[i] = pl_cell_reg[i-1];
        end
    end

    assign gt_prev    = {gt_reg[DEPTH-2:0], 1'b1};
    assign valid_prev = {valid_c[DEPTH-2:0], 1'b0};
    assign bound_c    = ~gt_reg & gt_prev;
    assign shift_c    = valid_prev & ~gt_prev;
    assign eq_any     = |eq_reg;

    always_comb begin
        pos_c = '0;
        for (int i = 0; i < DEPTH; i++) begin
            pos_c = pos_c | (bound_c[i] ? FW'(i) : '0);
        end
    end

    // Decide the outcome of the held command
    always_comb begin
        do_ins    = 1'b0;
        do_rep    = 1'b0;
        status_c  = sidl_pkg::ST_IGNORED;
        pos_out_c = '0;
        out_id_c  = '0;
        out_pl_c  = '0;
        unique case (cmd_reg.kind)
            sidl_pkg::CMD_READ: begin
                pos_out_c = sidl_pkg::POS_W'(cmd_reg.index);
                if (rd_ok_reg) begin
                    status_c = sidl_pkg::ST_READ_OK;
                    out_id_c = rd_id_reg;
                    out_pl_c = rd_pl_reg;
                end else begin
                    status_c = sidl_pkg::ST_READ_OOR;
                end
            end
            sidl_pkg::CMD_INSERT: begin
                if (eq_any) begin
                    do_rep    = 1'b1;
                    status_c  = sidl_pkg::ST_REPLACED;
                    pos_out_c = sidl_pkg::POS_W'(pos_c);
                end else if (full) begin
                    status_c  = sidl_pkg::ST_DROPPED;
                end else begin
                    do_ins    = 1'b1;
                    pos_out_c = sidl_pkg::POS_W'(pos_c);
                    status_c  = (pos_c == fill_reg) ? sidl_pkg::ST_APPENDED
                                                    : sidl_pkg::ST_INSERTED;
                end
            end
            default: begin
                status_c = sidl_pkg::ST_IGNORED;
            end
        endcase
    end

    assign fill_after = do_ins ? fill_reg + FW'(1) : fill_reg;
    assign result_c   = {out_pl_c, out_id_c, sidl_pkg::POS_W'(fill_after), pos_out_c};

    // Cell row: replace in place or open a gap and shift down
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (do_rep && eq_reg[i]) begin
                    pl_cell_reg[i] <= cmd_reg.payload;
                end else if (do_ins && bound_c[i]) begin
                    id_cell_reg[i] <= cmd_reg.id;
                    pl_cell_reg[i] <= cmd_reg.payload;
                end else if (do_ins && shift_c[i]) begin
                    id_cell_reg[i] <= id_prev[i];
                    pl_cell_reg[i] <= pl_prev[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg   <= q_cmd;
            gt_reg    <= gt_c;
            eq_reg    <= eq_c;
            rd_ok_reg <= |rd_sel_c;
            rd_id_reg <= rd_id_c;
            rd_pl_reg <= rd_pl_c;
        end
        if (exec_fire) begin
            m_data_reg <= sidl_pkg::M_TDATA_W'(result_c);
            m_user_reg <= status_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOOK;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_LOOK: begin
                    if (q_pop) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        state_reg <= S_LOOK;
                        fill_reg  <= fill_after;
                    end
                end
                default: begin
                    state_reg <= S_LOOK;
                end
            endcase
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_id_list_insert_top.sv
// Top level of the sorted id list insert block.
// Path: item -> command queue -> held command and compare registers -> output register.
// The back end takes one command at a time: all cells compare against it at once, then
// the row shifts or replaces once the output register is free; the queue holds up to two.
// Reset: the entry count, the command queue and the output register clear;
// stored entries are not cleared and are never visible beyond the entry count.
`default_nettype none

module sorted_id_list_insert_top #(
    parameter int DEPTH = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input item channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_id [63:0], entry_payload [95:64], read_index [101:96], zero pad
    input  wire logic [sidl_pkg::S_TDATA_W-1:0] s_tdata,
    // func: 0 insert, 1 read
    input  wire logic                           s_tuser,
    // result item channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // position [6:0], entry_count [13:7], out_id [77:14], out_payload [109:78], zero pad
    output logic [sidl_pkg::M_TDATA_W-1:0]      m_tdata,
    // status [2:0]
    output logic [sidl_pkg::ST_W-1:0]           m_tuser
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    sidl_pkg::cmd_t push_cmd;
    sidl_pkg::cmd_t head_cmd;

    // Classify items: read, default-id no-op, or insert
    sidl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Hold commands so the front keeps accepting while the back works
    sidl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    // Compare across the cell row, then replace, insert with shift, or read
    sidl_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the sorted id list insert block: stream driver, monitor, predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W      = sidl_pkg::ID_W;
    localparam int PL_W      = sidl_pkg::PL_W;
    localparam int IDX_W     = sidl_pkg::IDX_W;
    localparam int ST_W      = sidl_pkg::ST_W;
    localparam int POS_W     = sidl_pkg::POS_W;
    localparam int S_TDATA_W = sidl_pkg::S_TDATA_W;
    localparam int M_TDATA_W = sidl_pkg::M_TDATA_W;

    localparam int TBL_DEPTH   = 64;
    localparam int RAND_ITEMS  = 450;
    localparam int IDLE_LIMIT  = 3000;   // cycles with no handshake on either side
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int HOLD_AT     = 150;    // input items accepted before the hold-off
    localparam int CALM_LO     = 300;    // window of input items with no idling
    localparam int CALM_HI     = 360;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    localparam logic signed [ID_W-1:0] ID_MAX = {1'b0, {(ID_W-1){1'b1}}};
    localparam logic signed [ID_W-1:0] ID_MIN = {1'b1, {(ID_W-1){1'b0}}};

    // one input item
    typedef struct packed {
        logic                   func;
        logic signed [ID_W-1:0] id;
        logic [PL_W-1:0]        payload;
        logic [IDX_W-1:0]       index;
    } entry_req_t;

    // one result item
    typedef struct packed {
        logic [ST_W-1:0]        status;
        logic [POS_W-1:0]       position;
        logic [POS_W-1:0]       count;
        logic signed [ID_W-1:0] id;
        logic [PL_W-1:0]        payload;
    } entry_rsp_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [ST_W-1:0]        m_tuser;

    sorted_id_list_insert_top #(
        .DEPTH (TBL_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow of the entry table, advanced once per accepted input item.
    logic signed [ID_W-1:0] tbl_id [TBL_DEPTH];
    logic [PL_W-1:0]        tbl_pl [TBL_DEPTH];
    int                     tbl_cnt = 0;

    entry_req_t pending_q[$];    // items waiting to be offered
    entry_rsp_t result_q[$];     // results owed by the block, oldest first

    entry_req_t cur_req;
    int         n_in_acc  = 0;
    int         n_err     = 0;
    int         send_gap  = 0;
    int         rdy_gap   = 0;
    int         hold_cnt  = 0;
    bit         hold_done = 1'b0;
    int         idle_cnt  = 0;

    // Work out the result of one item and update the shadow table.
    task automatic predict_entry(input entry_req_t rq, output entry_rsp_t rs);
        int  p;
        int  k;
        bit  found;
        rs    = '0;
        found = 1'b0;
        p     = tbl_cnt;
        if (rq.func == FUNC_READ) begin
            rs.position = POS_W'(rq.index);
            if (int'(rq.index) < tbl_cnt) begin
                rs.status  = sidl_pkg::ST_READ_OK;
                rs.id      = tbl_id[rq.index];
                rs.payload = tbl_pl[rq.index];
            end else begin
                rs.status = sidl_pkg::ST_READ_OOR;
            end
        end else if (rq.id == sidl_pkg::DEFAULT_ID) begin
            rs.status = sidl_pkg::ST_IGNORED;
        end else begin
            // first slot whose id is not greater than the new one
            for (int i = 0; i < tbl_cnt; i++) begin
                if (!found && tbl_id[i] <= rq.id) begin
                    p     = i;
                    found = 1'b1;
                end
            end
            if (p < tbl_cnt && tbl_id[p] == rq.id) begin
                tbl_pl[p]   = rq.payload;
                rs.status   = sidl_pkg::ST_REPLACED;
                rs.position = POS_W'(p);
            end else if (tbl_cnt >= TBL_DEPTH) begin
                rs.status = sidl_pkg::ST_DROPPED;
            end else begin
                for (k = tbl_cnt; k > p; k--) begin
                    tbl_id[k] = tbl_id[k-1];
                    tbl_pl[k] = tbl_pl[k-1];
                end
                tbl_id[p]   = rq.id;
                tbl_pl[p]   = rq.payload;
                rs.status   = (p == tbl_cnt) ? sidl_pkg::ST_APPENDED
                                             : sidl_pkg::ST_INSERTED;
                rs.position = POS_W'(p);
                tbl_cnt++;
            end
        end
        rs.count = POS_W'(tbl_cnt);
    endtask

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit calm_window();
        return n_in_acc >= CALM_LO && n_in_acc < CALM_HI;
    endfunction

    task automatic push_req(input logic f, input logic signed [ID_W-1:0] id,
                            input logic [PL_W-1:0] pl, input logic [IDX_W-1:0] idx);
        entry_req_t rq;
        rq.func    = f;
        rq.id      = id;
        rq.payload = pl;
        rq.index   = idx;
        pending_q.push_back(rq);
    endtask

    // Clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Driver: offer the pending items, predict each one as it is accepted.
    always @(posedge aclk) begin
        entry_rsp_t rs;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_entry(cur_req, rs);
                result_q.push_back(rs);
                n_in_acc++;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur_req  = pending_q.pop_front();
                s_tdata  <= {{(S_TDATA_W-ID_W-PL_W-IDX_W){1'b0}},
                             cur_req.index, cur_req.payload, cur_req.id};
                s_tuser  <= cur_req.func;
                s_tvalid <= 1'b1;
                send_gap = calm_window() ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver readiness: random stalls, one long hold-off so the block backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (!hold_done && n_in_acc >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rdy_gap > 0) begin
            rdy_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm_window() && $urandom_range(0, 3) == 0) rdy_gap = pick_gap();
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        entry_rsp_t got;
        entry_rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status   = m_tuser;
            got.position = m_tdata[6:0];
            got.count    = m_tdata[13:7];
            got.id       = m_tdata[77:14];
            got.payload  = m_tdata[109:78];
            if (result_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result: status %0d pos %0d count %0d id %h pl %h",
                             got.status, got.position, got.count, got.id, got.payload);
            end else begin
                want = result_q.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("mismatch: expected status %0d pos %0d count %0d id %h pl %h",
                                 want.status, want.position, want.count, want.id,
                                 want.payload);
                        $display("          actual   status %0d pos %0d count %0d id %h pl %h",
                                 got.status, got.position, got.count, got.id, got.payload);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= IDLE_LIMIT) begin
            $display("[sorted_id_list_insert_top] ERROR");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // Stimulus and end of run.
    initial begin
        logic signed [ID_W-1:0] id_pool[$];
        logic signed [ID_W-1:0] nid;
        int                     est_cnt;
        int                     r;
        bit                     seen;

        // empty table reads, default id, extremes, replace at both ends
        push_req(FUNC_READ,   '0,                   '0,            6'd0);
        push_req(FUNC_READ,   '0,                   '0,            6'd63);
        push_req(FUNC_INSERT, sidl_pkg::DEFAULT_ID, 32'h1234_5678, 6'd0);
        push_req(FUNC_INSERT, 64'sd0,               32'h0000_0000, 6'd0);
        push_req(FUNC_INSERT, ID_MAX,               32'hFFFF_FFFF, 6'd0);
        push_req(FUNC_INSERT, ID_MIN,               32'h8000_0001, 6'd0);
        push_req(FUNC_INSERT, 64'sd0,               32'hA5A5_A5A5, 6'd0);
        push_req(FUNC_INSERT, -64'sd2,              32'h5A5A_5A5A, 6'd0);
        push_req(FUNC_INSERT, 64'sd100,             32'h0000_0064, 6'd0);
        push_req(FUNC_INSERT, ID_MIN,               32'h1111_1111, 6'd0);
        push_req(FUNC_INSERT, ID_MAX,               32'h2222_2222, 6'd0);
        push_req(FUNC_INSERT, sidl_pkg::DEFAULT_ID, 32'hFFFF_FFFF, 6'd63);
        for (int i = 0; i < 6; i++) push_req(FUNC_READ, '0, '0, IDX_W'(i));
        // read ignores the id and payload fields
        push_req(FUNC_READ,   sidl_pkg::DEFAULT_ID, 32'hFFFF_FFFF, 6'd2);
        push_req(FUNC_READ,   ID_MAX,               32'hDEAD_BEEF, 6'd63);
        id_pool = '{ID_MAX, 64'sd100, 64'sd0, -64'sd2, ID_MIN};

        // random part: mostly well-formed inserts and in-range reads, some noise
        for (int n = 0; n < RAND_ITEMS; n++) begin
            est_cnt = id_pool.size();
            r = $urandom_range(0, 99);
            if (r < 30 && est_cnt > 0) begin
                push_req(FUNC_READ, {$urandom, $urandom}, $urandom,
                         IDX_W'($urandom_range(0, est_cnt - 1)));
            end else if (r < 36) begin
                push_req(FUNC_READ, {$urandom, $urandom}, $urandom,
                         IDX_W'($urandom_range(0, 63)));
            end else if (r < 48 && est_cnt > 0) begin
                push_req(FUNC_INSERT, id_pool[$urandom_range(0, est_cnt - 1)],
                         $urandom, IDX_W'($urandom));
            end else if (r < 53) begin
                push_req(FUNC_INSERT, sidl_pkg::DEFAULT_ID, $urandom, IDX_W'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0: nid = $signed(64'($urandom_range(0, 100))) - 64'sd50;
                    1: nid = ID_MAX - 64'($urandom_range(0, 20));
                    2: nid = ID_MIN + 64'($urandom_range(0, 20));
                    default: nid = {$urandom, $urandom};
                endcase
                push_req(FUNC_INSERT, nid, $urandom, IDX_W'($urandom));
                seen = (nid == sidl_pkg::DEFAULT_ID);
                foreach (id_pool[j]) if (id_pool[j] == nid) seen = 1'b1;
                // only ids that actually land in the table can be replaced later
                if (!seen && id_pool.size() < TBL_DEPTH) id_pool.push_back(nid);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (result_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (n_err == 0) begin
            $display("[sorted_id_list_insert_top] OK");
        end else begin
            $display("[sorted_id_list_insert_top] ERROR");
        end
        $finish;
    end

endmodule
